[rtl/isfd_pkg.sv]
package isfd_pkg;

  // Frame layout.
  localparam int unsigned FrameBytes = 11;
  localparam int unsigned WinIdxW    = $clog2(FrameBytes);
  localparam int unsigned FillW      = $clog2(FrameBytes + 1);
  localparam int unsigned DataBytes  = 8;
  localparam int unsigned DataW      = 8 * DataBytes;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeGyro  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;
  localparam logic [7:0] TypeGps   = 8'h57;
  localparam logic [7:0] TypeQuat  = 8'h59;

  // Work handed from the frame scanner to the record builder.
  typedef enum logic [1:0] {
    CMD_ACCEL,
    CMD_GYRO,
    CMD_QUAT,
    CMD_GPS
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [DataW-1:0] data;
  } cmd_t;

  // Record kinds as seen on the result port.
  localparam logic [1:0] RecOrient = 2'd0;
  localparam logic [1:0] RecRate   = 2'd1;
  localparam logic [1:0] RecAccel  = 2'd2;
  localparam logic [1:0] RecPos    = 2'd3;

  localparam int unsigned AxisW = 16;
  localparam int unsigned PosW  = 33;
  localparam int unsigned RawW  = 32;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    present;
    logic signed [AxisW-1:0] x;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] z;
    logic signed [AxisW-1:0] w;
    logic [PosW-1:0]         lat;
    logic [PosW-1:0]         lon;
    logic                    last;
  } rec_t;

  // Position correction constants.
  localparam int unsigned ScaleW   = 24;
  localparam logic [ScaleW-1:0] DegScale = 24'd10000000;
  localparam int unsigned DegW     = 9;   // raw / 1e7 is at most 429
  localparam int unsigned FracW    = 26;  // 5 * (raw mod 1e7) stays below 2^26
  localparam int unsigned ProdW    = 2 * FracW;
  localparam logic [FracW-1:0] ThirdRecip = 26'd44739243;  // ceil(2^27 / 3)
  localparam int unsigned ThirdShift = 27;

  // 1e7 is 2^7 * 78125: drop seven low bits, then multiply by ceil(2^42 / 78125).
  localparam int unsigned DivShift = 7;
  localparam int unsigned DivInW   = RawW - DivShift;
  localparam int unsigned RecipW   = 26;
  localparam logic [RecipW-1:0] DegRecip = 26'd56294996;
  localparam int unsigned DegShift = 42;
  localparam int unsigned DegProdW = DivInW + RecipW;

  // Queue depths.
  localparam int unsigned CmdDepthDef = 2;
  localparam int unsigned OutDepthDef = 4;

endpackage

[rtl/imu_serial_frame_decoder.sv]
// Serial IMU frame decoder. Received UART bytes are pushed in arrival order; the block hunts
// for 11-byte frames (0x55 header, a known type byte, eight little-endian data bytes and an
// 8-bit additive checksum over the first ten bytes), sliding forward one byte whenever the
// header, type or checksum does not match. Accel (0x51) and gyro (0x52) frames only update
// internal raw triples, and 0x53 frames are swallowed. A quaternion frame (0x59) yields three
// records in order: orientation, angular rate, acceleration; a GPS frame (0x57) yields one
// position record with latitude and longitude corrected to units of 1e-7 degree. The last
// record caused by a byte carries last_o. The front end takes a pushed byte into a one-word
// hold register, which can take a new byte while the previous one is scanned. Each byte enters
// the window in the idle state and is checked in the scan state, which also discards one byte
// per step while resynchronizing. Decoded frames pass through a short command queue to the
// back end. It stores an accel or gyro frame at once, pushes a quaternion frame's records one
// per step while the output queue has room, and runs the four-stage position converter
// (reciprocal multiply for the division by 1e7, remainder, five-thirds scaling, final sum)
// for a GPS frame. Results wait in an output queue, so the scanner keeps taking bytes while
// earlier records are still waiting to be popped. There is no start-up sweep after reset.

module imu_serial_frame_decoder #(
  parameter int unsigned CmdDepth = isfd_pkg::CmdDepthDef,
  parameter int unsigned OutDepth = isfd_pkg::OutDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [7:0]                        rx_byte_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [1:0]                        record_kind_o,
  output logic                              present_o,
  output logic signed [isfd_pkg::AxisW-1:0] axis_x_o,
  output logic signed [isfd_pkg::AxisW-1:0] axis_y_o,
  output logic signed [isfd_pkg::AxisW-1:0] axis_z_o,
  output logic signed [isfd_pkg::AxisW-1:0] axis_w_o,
  output logic [isfd_pkg::PosW-1:0]         latitude_o,
  output logic [isfd_pkg::PosW-1:0]         longitude_o,
  output logic                              last_o
);

  import isfd_pkg::*;

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  rec_t rec_in, rec_head;
  logic rec_push, rec_full;

  // Front end: byte window, header and type check, running checksum.
  isfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .cmd_full_i (cmd_full)
  );

  // Decoded frames waiting for the back end.
  isfd_fifo #(
    .item_t (cmd_t),
    .Depth  (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_head),
    .empty_o (cmd_empty)
  );

  // Back end: sensor stores, record assembly and position conversion.
  isfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .rec_full_i  (rec_full),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  // Finished records; the head of this queue drives the result ports.
  isfd_fifo #(
    .item_t (rec_t),
    .Depth  (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (pop),
    .data_o  (rec_head),
    .empty_o (empty)
  );

  assign record_kind_o = rec_head.kind;
  assign present_o     = rec_head.present;
  assign axis_x_o      = rec_head.x;
  assign axis_y_o      = rec_head.y;
  assign axis_z_o      = rec_head.z;
  assign axis_w_o      = rec_head.w;
  assign latitude_o    = rec_head.lat;
  assign longitude_o   = rec_head.lon;
  assign last_o        = rec_head.last;

endmodule

[rtl/isfd_fifo.sv]
module isfd_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned Depth  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  item_t           slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/isfd_front.sv]
module isfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [7:0]     rx_byte_i,
  output logic           full_o,
  output logic           cmd_push_o,
  output isfd_pkg::cmd_t cmd_o,
  input  logic           cmd_full_i
);

  import isfd_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  localparam logic [FillW-1:0] FillFull = FillW'(FrameBytes);
  localparam logic [FillW-1:0] FillType = FillW'(2);

  logic             state_q, state_d;
  logic             hold_v_q, hold_v_d;
  logic [7:0]       hold_q;
  logic [7:0]       win_q [FrameBytes];
  logic [7:0]       win_d [FrameBytes];
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       sum_q, sum_d;
  logic             take, push_acc, known, sum_ok, drop, clear;

  // One byte waits in the hold register while the window is being scanned.
  assign take     = (state_q == StIdle) && hold_v_q;
  assign full_o   = hold_v_q && !take;
  assign push_acc = push_i && !full_o;
  assign hold_v_d = push_acc || (hold_v_q && !take);

  assign known = win_q[1] inside {TypeAccel, TypeGyro, TypeAngle, TypeGps, TypeQuat};
  // The running sum covers all eleven bytes; take the checksum byte back out.
  assign sum_ok = ((sum_q - win_q[FrameBytes-1]) == win_q[FrameBytes-1]);

  always_comb begin
    for (int k = 0; k < DataBytes; k++) begin
      cmd_o.data[8*k +: 8] = win_q[k+2];
    end
    unique case (win_q[1])
      TypeAccel: cmd_o.kind = CMD_ACCEL;
      TypeGyro:  cmd_o.kind = CMD_GYRO;
      TypeQuat:  cmd_o.kind = CMD_QUAT;
      default:   cmd_o.kind = CMD_GPS;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    win_d      = win_q;
    drop       = 1'b0;
    clear      = 1'b0;
    cmd_push_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (hold_v_q) begin
          win_d[fill_q[WinIdxW-1:0]] = hold_q;
          fill_d  = fill_q + 1'b1;
          sum_d   = sum_q + hold_q;
          state_d = StScan;
        end
      end
      StScan: begin
        if (fill_q == '0) begin
          state_d = StIdle;
        end else if (win_q[0] != HdrByte) begin
          drop = 1'b1;
        end else if (fill_q < FillType) begin
          state_d = StIdle;
        end else if (!known) begin
          drop = 1'b1;
        end else if (fill_q < FillFull) begin
          state_d = StIdle;
        end else if (!sum_ok) begin
          drop = 1'b1;
        end else if (win_q[1] == TypeAngle) begin
          clear   = 1'b1;
          state_d = StIdle;
        end else if (!cmd_full_i) begin
          cmd_push_o = 1'b1;
          clear      = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
    if (drop) begin
      for (int i = 0; i < FrameBytes - 1; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[FrameBytes-1] = '0;
      fill_d = fill_q - 1'b1;
      sum_d  = sum_q - win_q[0];
    end
    if (clear) begin
      fill_d = '0;
      sum_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      hold_v_q <= 1'b0;
      fill_q   <= '0;
      sum_q    <= '0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      hold_q <= rx_byte_i;
    end
    win_q <= win_d;
  end

endmodule

[rtl/isfd_pos_fix.sv]
module isfd_pos_fix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [isfd_pkg::RawW-1:0] raw_i,
  output logic                      done_o,
  output logic [isfd_pkg::PosW-1:0] value_o
);

  import isfd_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StRem  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StSum  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [RawW-1:0]     raw_q, raw_d;
  logic [DegW-1:0]     deg_q, deg_d;
  logic [ScaleW-1:0]   rem_q, rem_d;
  logic [ProdW-1:0]    frac_prod_q, frac_prod_d;
  logic [PosW-1:0]     deg_prod_q, deg_prod_d;
  logic [PosW-1:0]     value_q, value_d;
  logic                done_q, done_d;
  logic [DegProdW-1:0] deg_recip;
  logic [PosW-1:0]     deg_full;
  logic [RawW-1:0]     rem_wide;
  logic [FracW-1:0]    times5;

  // Whole degrees by a reciprocal multiply, exact for every 32-bit raw value.
  assign deg_recip = raw_q[RawW-1:DivShift] * DegRecip;
  assign deg_full  = deg_q * DegScale;
  assign rem_wide  = raw_q - deg_full[RawW-1:0];
  assign times5    = {rem_q, 2'b00} + FracW'(rem_q);

  always_comb begin
    state_d     = state_q;
    raw_d       = raw_q;
    deg_d       = deg_q;
    rem_d       = rem_q;
    frac_prod_d = frac_prod_q;
    deg_prod_d  = deg_prod_q;
    value_d     = value_q;
    done_d      = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          raw_d   = raw_i;
          state_d = StDiv;
        end
      end
      StDiv: begin
        deg_d   = deg_recip[DegProdW-1:DegShift];
        state_d = StRem;
      end
      StRem: begin
        deg_prod_d = deg_full;
        rem_d      = rem_wide[ScaleW-1:0];
        state_d    = StMul;
      end
      StMul: begin
        // Five thirds of the minutes field, by multiplying with a rounded-up reciprocal.
        frac_prod_d = times5 * ThirdRecip;
        state_d     = StSum;
      end
      StSum: begin
        value_d = deg_prod_q + PosW'(frac_prod_q[ProdW-1:ThirdShift]);
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q       <= raw_d;
    deg_q       <= deg_d;
    rem_q       <= rem_d;
    frac_prod_q <= frac_prod_d;
    deg_prod_q  <= deg_prod_d;
    value_q     <= value_d;
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

[rtl/isfd_back.sv]
module isfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  isfd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  input  logic           rec_full_i,
  output logic           rec_push_o,
  output isfd_pkg::rec_t rec_o
);

  import isfd_pkg::*;

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StQuat    = 2'd1;
  localparam logic [1:0] StGpsWait = 2'd2;
  localparam logic [1:0] StGpsEmit = 2'd3;

  localparam logic [1:0] IdxOrient = 2'd0;
  localparam logic [1:0] IdxRate   = 2'd1;

  logic [1:0]       state_q, state_d;
  logic [1:0]       idx_q, idx_d;
  logic [DataW-1:0] data_q;
  logic [AxisW-1:0] accel_q [3];
  logic [AxisW-1:0] gyro_q [3];
  logic             accel_seen_q, gyro_seen_q;
  logic             pos_start, lat_done, lon_done;
  logic [PosW-1:0]  lat_value, lon_value;
  logic             take_accel, take_gyro;

  // Both converters start together and take the same number of cycles.
  isfd_pos_fix u_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pos_start),
    .raw_i   (cmd_i.data[DataW-1:RawW]),
    .done_o  (lat_done),
    .value_o (lat_value)
  );

  isfd_pos_fix u_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (pos_start),
    .raw_i   (cmd_i.data[RawW-1:0]),
    .done_o  (lon_done),
    .value_o (lon_value)
  );

  assign take_accel = cmd_pop_o && (cmd_i.kind == CMD_ACCEL);
  assign take_gyro  = cmd_pop_o && (cmd_i.kind == CMD_GYRO);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_pop_o  = 1'b0;
    pos_start  = 1'b0;
    rec_push_o = 1'b0;
    rec_o      = '0;
    unique case (state_q)
      StIdle: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_QUAT: begin
              idx_d   = IdxOrient;
              state_d = StQuat;
            end
            CMD_GPS: begin
              pos_start = 1'b1;
              state_d   = StGpsWait;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StQuat: begin
        if (idx_q == IdxOrient) begin
          rec_o.kind    = RecOrient;
          rec_o.present = 1'b1;
          rec_o.w       = data_q[15:0];
          rec_o.x       = data_q[31:16];
          rec_o.y       = data_q[47:32];
          rec_o.z       = data_q[63:48];
        end else if (idx_q == IdxRate) begin
          rec_o.kind    = RecRate;
          rec_o.present = gyro_seen_q;
          rec_o.x       = gyro_q[0];
          rec_o.y       = gyro_q[1];
          rec_o.z       = gyro_q[2];
        end else begin
          rec_o.kind    = RecAccel;
          rec_o.present = accel_seen_q;
          rec_o.x       = accel_q[0];
          rec_o.y       = accel_q[1];
          rec_o.z       = accel_q[2];
          rec_o.last    = 1'b1;
        end
        if (!rec_full_i) begin
          rec_push_o = 1'b1;
          idx_d      = idx_q + 1'b1;
          if (rec_o.last) begin
            state_d = StIdle;
          end
        end
      end
      StGpsWait: begin
        if (lat_done && lon_done) begin
          state_d = StGpsEmit;
        end
      end
      StGpsEmit: begin
        rec_o.kind    = RecPos;
        rec_o.present = 1'b1;
        rec_o.lat     = lat_value;
        rec_o.lon     = lon_value;
        rec_o.last    = 1'b1;
        if (!rec_full_i) begin
          rec_push_o = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      idx_q        <= IdxOrient;
      accel_seen_q <= 1'b0;
      gyro_seen_q  <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        accel_q[i] <= '0;
        gyro_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (take_accel) begin
        accel_seen_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          accel_q[i] <= cmd_i.data[AxisW*i +: AxisW];
        end
      end
      if (take_gyro) begin
        gyro_seen_q <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          gyro_q[i] <= cmd_i.data[AxisW*i +: AxisW];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      data_q <= cmd_i.data;
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import isfd_pkg::*;

  // Run-length knobs.
  localparam int unsigned HoldCycles     = 400;  // long receiver hold-off
  localparam int unsigned SettleCycles   = 40;   // covers the slow position path
  localparam int unsigned RandFrameBytes = 22;   // framed bytes in the random stream
  localparam int unsigned SteadyBytes    = 11;   // framed bytes sent without idling
  localparam int unsigned MinRandRecords = 2;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic push    = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic pop     = 1'b0;
  logic full;
  logic empty;
  logic [1:0]              record_kind;
  logic                    present;
  logic signed [AxisW-1:0] axis_x;
  logic signed [AxisW-1:0] axis_y;
  logic signed [AxisW-1:0] axis_z;
  logic signed [AxisW-1:0] axis_w;
  logic [PosW-1:0]         latitude;
  logic [PosW-1:0]         longitude;
  logic                    last;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  imu_serial_frame_decoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .rx_byte_i    (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .record_kind_o(record_kind),
    .present_o    (present),
    .axis_x_o     (axis_x),
    .axis_y_o     (axis_y),
    .axis_z_o     (axis_z),
    .axis_w_o     (axis_w),
    .latitude_o   (latitude),
    .longitude_o  (longitude),
    .last_o       (last)
  );

  // Shadow copy of the decoder state. It is updated at the clock edge where a word is
  // accepted, so the queue of expected records always leads the block's output.
  logic [7:0]  win_q [FrameBytes];
  int unsigned win_fill = 0;
  logic [15:0] accel_xyz [3];
  logic [15:0] gyro_xyz [3];
  logic        accel_seen = 1'b0;
  logic        gyro_seen  = 1'b0;
  rec_t        pending_recs [$];

  // Traffic shaping shared by the sender, the receiver and the test tasks.
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;

  int unsigned fail_count      = 0;
  int unsigned bytes_sent      = 0;
  int unsigned records_queued  = 0;
  int unsigned records_checked = 0;
  int unsigned quat_frames     = 0;
  int unsigned gps_frames      = 0;
  int unsigned store_frames    = 0;

  initial begin
    for (int i = 0; i < FrameBytes; i++) win_q[i] = 8'h00;
    for (int i = 0; i < 3; i++) begin
      accel_xyz[i] = 16'h0000;
      gyro_xyz[i]  = 16'h0000;
    end
  end

  function automatic logic [15:0] win_word(input int unsigned idx);
    return {win_q[idx + 1], win_q[idx]};
  endfunction

  // The raw GPS value is in DDDmm.mmmmm form; the minutes part is scaled by 100/60 so
  // the whole value ends up in units of 1e-7 degree.
  function automatic logic [PosW-1:0] gps_to_units(input int unsigned idx);
    longint unsigned raw;
    longint unsigned deg;
    longint unsigned rem;
    raw = {win_q[idx + 3], win_q[idx + 2], win_q[idx + 1], win_q[idx]};
    deg = raw / 64'd10000000;
    rem = raw % 64'd10000000;
    return PosW'(deg * 64'd10000000 + (rem * 64'd5) / 64'd3);
  endfunction

  function automatic rec_t make_rec(input logic [1:0] kind, input logic pres,
                                    input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] z, input logic [15:0] w,
                                    input logic [PosW-1:0] lat, input logic [PosW-1:0] lon,
                                    input logic is_last);
    rec_t r;
    r.kind    = kind;
    r.present = pres;
    r.x       = x;
    r.y       = y;
    r.z       = z;
    r.w       = w;
    r.lat     = lat;
    r.lon     = lon;
    r.last    = is_last;
    return r;
  endfunction

  function automatic void drop_lead();
    for (int i = 0; i < FrameBytes - 1; i++) win_q[i] = win_q[i + 1];
    win_q[FrameBytes - 1] = 8'h00;
    win_fill--;
  endfunction

  // Act on a complete, checksum-clean frame sitting in the window.
  function automatic void apply_frame();
    case (win_q[1])
      TypeAccel: begin
        for (int i = 0; i < 3; i++) accel_xyz[i] = win_word(2 + 2 * i);
        accel_seen = 1'b1;
        store_frames++;
      end
      TypeGyro: begin
        for (int i = 0; i < 3; i++) gyro_xyz[i] = win_word(2 + 2 * i);
        gyro_seen = 1'b1;
        store_frames++;
      end
      TypeQuat: begin
        pending_recs.push_back(make_rec(RecOrient, 1'b1, win_word(4), win_word(6),
                                        win_word(8), win_word(2), '0, '0, 1'b0));
        pending_recs.push_back(make_rec(RecRate, gyro_seen, gyro_xyz[0], gyro_xyz[1],
                                        gyro_xyz[2], 16'h0000, '0, '0, 1'b0));
        pending_recs.push_back(make_rec(RecAccel, accel_seen, accel_xyz[0], accel_xyz[1],
                                        accel_xyz[2], 16'h0000, '0, '0, 1'b1));
        records_queued += 3;
        quat_frames++;
      end
      TypeGps: begin
        pending_recs.push_back(make_rec(RecPos, 1'b1, 16'h0000, 16'h0000, 16'h0000,
                                        16'h0000, gps_to_units(6), gps_to_units(2), 1'b1));
        records_queued++;
        gps_frames++;
      end
      default: begin
        // Angle frames are consumed without any effect.
      end
    endcase
  endfunction

  // Feed one received word into the shadow scanner. A bad header, an unknown type or a
  // failed checksum drops the leading word and the rest of the window is scanned again.
  function automatic void decode_byte(input logic [7:0] b);
    logic [7:0] sum;
    bit         done;
    if (win_fill >= FrameBytes) win_fill = FrameBytes - 1;
    win_q[win_fill] = b;
    win_fill++;
    done = 1'b0;
    while (!done) begin
      if (win_fill == 0) begin
        done = 1'b1;
      end else if (win_q[0] != HdrByte) begin
        drop_lead();
      end else if (win_fill < 2) begin
        done = 1'b1;
      end else if (!(win_q[1] inside {TypeAccel, TypeGyro, TypeAngle, TypeGps, TypeQuat}))
      begin
        drop_lead();
      end else if (win_fill < FrameBytes) begin
        done = 1'b1;
      end else begin
        sum = 8'h00;
        for (int i = 0; i < FrameBytes - 1; i++) sum += win_q[i];
        if (sum != win_q[FrameBytes - 1]) begin
          drop_lead();
        end else begin
          apply_frame();
          for (int i = 0; i < FrameBytes; i++) win_q[i] = 8'h00;
          win_fill = 0;
          done = 1'b1;
        end
      end
    end
  endfunction

  // Offer one word, with random idle cycles ahead of it unless the sender runs steady.
  // The push stays high across back-to-back words, so it is never dropped and raised in
  // the same time step.
  task automatic send_byte(input logic [7:0] b);
    if (!send_steady) begin
      while ($urandom_range(99) < 38) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
    decode_byte(b);
    bytes_sent++;
  endtask

  // Body bytes are frame bytes two to nine, lowest byte first.
  task automatic send_frame(input logic [7:0] ftype, input logic [63:0] body,
                            input bit bad_sum = 1'b0);
    logic [7:0] sum;
    sum = HdrByte + ftype;
    for (int i = 0; i < DataBytes; i++) sum += body[8 * i +: 8];
    send_byte(HdrByte);
    send_byte(ftype);
    for (int i = 0; i < DataBytes; i++) send_byte(body[8 * i +: 8]);
    send_byte(bad_sum ? (sum ^ 8'(1 << $urandom_range(7))) : sum);
  endtask

  // Stop offering and wait until every expected record has been taken, then a little
  // longer so that a stray extra record would still be caught.
  task automatic drain_records();
    push <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Receiver: random pops, a steady mode, and a long hold-off counted here on request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= take_steady || ($urandom_range(99) >= 38);
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Every record taken from the block is compared with the oldest expected one.
  always @(posedge clk_i) begin : check_records
    rec_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_recs.size() == 0) begin
        $error("record of kind %0d arrived with none expected", record_kind);
        fail_count++;
      end else begin
        want = pending_recs.pop_front();
        check_field("record_kind", want.kind, record_kind);
        check_field("present", want.present, present);
        check_field("axis_x", want.x, axis_x);
        check_field("axis_y", want.y, axis_y);
        check_field("axis_z", want.z, axis_z);
        check_field("axis_w", want.w, axis_w);
        check_field("latitude", want.lat, latitude);
        check_field("longitude", want.lon, longitude);
        check_field("last", want.last, last);
        records_checked++;
      end
    end
  end

  // A quaternion frame straight after reset reports rate and accel as never seen.
  task automatic test_quat_before_stores();
    send_frame(TypeQuat, {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF});
  endtask

  // Accel, gyro and angle frames produce nothing themselves; the next quaternion frame
  // shows the stored triples with their flags set.
  task automatic test_store_frames();
    send_frame(TypeAccel, {16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000});
    send_frame(TypeGyro, {16'h0000, 16'h8000, 16'h0001, 16'hFFFF});
    send_frame(TypeAngle, {$urandom, $urandom});
    send_frame(TypeQuat, {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF});
  endtask

  // Position extremes: the largest raw value, zero, a whole degree and the largest
  // minutes part.
  task automatic test_gps_limits();
    send_frame(TypeGps, {32'hFFFF_FFFF, 32'h0000_0000});
    send_frame(TypeGps, {32'd9999999, 32'd10000000});
  endtask

  // Noise, an unknown type, a doubled header, a bad checksum and a truncated frame must
  // each let the scanner lock on to the good frame that follows.
  task automatic test_resync();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h54);
    send_frame(TypeGps, {$urandom, $urandom});
    send_byte(HdrByte);
    send_byte(8'h50);
    send_byte(HdrByte);
    send_frame(TypeQuat, {$urandom, $urandom});
    send_frame(TypeAccel, {$urandom, $urandom}, 1'b1);
    send_frame(TypeQuat, {$urandom, $urandom});
    send_byte(HdrByte);
    send_byte(TypeGyro);
    send_frame(TypeQuat, {$urandom, $urandom});
  endtask

  // The receiver holds off for a long time while the sender streams quaternion frames,
  // so the output side fills up and the input must stall. Once the hold-off ends both
  // sides run with no idling, then the sender waits for every record to drain.
  task automatic test_back_pressure();
    send_steady = 1'b1;
    take_steady = 1'b1;
    hold_req    = 1'b1;
    for (int n = 0; n < 6; n++) send_frame(TypeQuat, {$urandom, $urandom});
    send_steady = 1'b0;
    take_steady = 1'b0;
    drain_records();
  endtask

  // Mostly well-formed frames with random content; the rest are corrupted checksums,
  // stray words and truncated frames. Nothing idles until SteadyBytes framed bytes are sent.
  task automatic test_random_stream();
    int unsigned framed;
    int unsigned rec_base;
    int unsigned pick;
    logic [7:0]  ftype;
    framed   = 0;
    rec_base = records_queued;
    while (framed < RandFrameBytes || records_queued - rec_base < MinRandRecords) begin
      send_steady = (framed < SteadyBytes);
      take_steady = send_steady;
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0, 1, 2: ftype = TypeQuat;
        3, 4:    ftype = TypeGps;
        5:       ftype = TypeAccel;
        6:       ftype = TypeGyro;
        7:       ftype = TypeAngle;
        default: ftype = ($urandom_range(1) != 0) ? TypeAccel : TypeGyro;
      endcase
      if (pick < 72) begin
        send_frame(ftype, {$urandom, $urandom});
        framed += FrameBytes;
      end else if (pick < 84) begin
        send_frame(ftype, {$urandom, $urandom}, 1'b1);
        framed += FrameBytes;
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_byte(HdrByte);
        send_byte(ftype);
        repeat ($urandom_range(0, DataBytes)) send_byte(8'($urandom));
        framed += 2;
      end
    end
    send_steady = 1'b0;
    take_steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quat_before_stores();
    test_store_frames();
    test_gps_limits();
    test_resync();
    test_back_pressure();
    test_random_stream();
    drain_records();

    $display("Sent %0d words: %0d quaternion, %0d position, %0d accel/gyro frames decoded.",
             bytes_sent, quat_frames, gps_frames, store_frames);
    $display("Checked %0d records, including a long output stall and resync cases.",
             records_checked);
    if (fail_count == 0) begin
      $display("[imu_serial_frame_decoder] OK");
    end else begin
      $display("[imu_serial_frame_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #400000;
    $display("[imu_serial_frame_decoder] ERROR");
    $finish;
  end

endmodule
